[sv/evq_pkg.sv]
package evq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned PAY_W  = 32;
  localparam int unsigned CODE_W = 16;
  localparam int unsigned DROP_W = 16;
  localparam int unsigned IN_W   = 72;
  localparam int unsigned OUT_W  = 88;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_t;

  typedef enum logic {
    MODE_POST = 1'b0,
    MODE_TAKE = 1'b1
  } mode_t;

  typedef enum logic {
    CFG_ANY_CLASS = 1'b0,
    CFG_ANY_TYPE  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [PAY_W-1:0]  payload;
    logic [CODE_W-1:0] ev_type;
    logic [CODE_W-1:0] ev_class;
  } entry_t;

endpackage

[sv/event_queue_match_take_core.sv]
// Event queue: holds up to 16 events in arrival order in one synchronous memory.
// A post (mode 0) is stored, or dropped and counted when the queue is full.
// A take (mode 1) scans the queue oldest first, one memory read and compare per entry,
// then closes the gap by moving every younger entry down one place, one memory read
// and write per entry. Scanned plus moved never exceeds the entries held. The memory
// gives one read per cycle, which sets the pace of a take.
// A finished result waits in the output register while the next item is accepted.
module event_queue_match_take_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // mode, event_class, event_type, payload (zero fill to 72)
  input  logic [evq_pkg::IN_W-1:0]         in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status, out_class, out_type, out_payload, held_count, dropped_total (zero fill to 88)
  output logic [evq_pkg::OUT_W-1:0]        out_tdata,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [evq_pkg::CODE_W-1:0]       cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SRD  = 6'b000010,
    S_SCMP = 6'b000100,
    S_MRD  = 6'b001000,
    S_MWR  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  evq_pkg::entry_t              mem [evq_pkg::DEPTH];
  evq_pkg::entry_t              rdata_r;
  logic [evq_pkg::ADDR_W-1:0]   rd_addr;
  logic                         wr_en;
  logic [evq_pkg::ADDR_W-1:0]   wr_addr;
  evq_pkg::entry_t              wr_data;

  logic [evq_pkg::CODE_W-1:0]   any_class_r, any_type_r;
  logic [evq_pkg::CNT_W-1:0]    occ_r, occ_nxt;
  logic [evq_pkg::DROP_W-1:0]   drop_r, drop_nxt;
  logic [evq_pkg::ADDR_W-1:0]   k_r, k_nxt, j_r, j_nxt;
  evq_pkg::entry_t              req_r, req_nxt;
  evq_pkg::status_t             res_st_r, res_st_nxt;
  evq_pkg::entry_t              res_r, res_nxt;
  logic                         out_valid_r;
  logic [evq_pkg::OUT_W-1:0]    out_data_r;

  evq_pkg::entry_t              in_entry;
  logic                         in_mode;
  logic                         in_acc;
  logic                         match;
  logic                         load_out;
  logic [evq_pkg::CNT_W-1:0]    k_ext, j_ext;

  assign in_mode   = in_tdata[0];
  assign in_entry  = in_tdata[64:1];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign k_ext     = {1'b0, k_r};
  assign j_ext     = {1'b0, j_r};

  assign match = ((req_r.ev_class == any_class_r) || (rdata_r.ev_class == req_r.ev_class)) &&
                 ((req_r.ev_type == any_type_r) || (rdata_r.ev_type == req_r.ev_type));

  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt  = state_r;
    occ_nxt    = occ_r;
    drop_nxt   = drop_r;
    k_nxt      = k_r;
    j_nxt      = j_r;
    req_nxt    = req_r;
    res_st_nxt = res_st_r;
    res_nxt    = res_r;
    rd_addr    = k_r;
    wr_en      = 1'b0;
    wr_addr    = occ_r[evq_pkg::ADDR_W-1:0];
    wr_data    = in_entry;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt    = in_entry;
          res_nxt    = '0;
          res_st_nxt = evq_pkg::ST_DONE;
          k_nxt      = '0;
          state_nxt  = S_DONE;
          if (in_mode == evq_pkg::MODE_POST) begin
            if (occ_r < evq_pkg::CNT_W'(evq_pkg::DEPTH)) begin
              wr_en   = 1'b1;
              occ_nxt = occ_r + 1'b1;
            end else begin
              drop_nxt   = drop_r + 1'b1;
              res_st_nxt = evq_pkg::ST_FULL;
            end
          end else if (occ_r == '0) begin
            res_st_nxt = evq_pkg::ST_NOMATCH;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      S_SRD: begin
        rd_addr   = k_r;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (match) begin
          res_nxt = rdata_r;
          if (k_ext + 1'b1 < occ_r) begin
            j_nxt     = k_r;
            state_nxt = S_MRD;
          end else begin
            occ_nxt   = occ_r - 1'b1;
            state_nxt = S_DONE;
          end
        end else if (k_ext + 1'b1 < occ_r) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_SRD;
        end else begin
          res_st_nxt = evq_pkg::ST_NOMATCH;
          state_nxt  = S_DONE;
        end
      end
      S_MRD: begin
        rd_addr   = j_r + 1'b1;
        state_nxt = S_MWR;
      end
      S_MWR: begin
        // move the younger entry down into the gap
        wr_en   = 1'b1;
        wr_addr = j_r;
        wr_data = rdata_r;
        j_nxt   = j_r + 1'b1;
        if (j_ext + 2'd2 < occ_r) begin
          state_nxt = S_MRD;
        end else begin
          occ_nxt   = occ_r - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    j_r      <= j_nxt;
    req_r    <= req_nxt;
    res_st_r <= res_st_nxt;
    res_r    <= res_nxt;
    if (load_out) begin
      out_data_r <= {1'b0, drop_r, occ_r, res_r.payload, res_r.ev_type, res_r.ev_class,
                     res_st_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      drop_r      <= '0;
      out_valid_r <= 1'b0;
      any_class_r <= '1;
      any_type_r  <= '1;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      drop_r  <= drop_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          evq_pkg::CFG_ANY_CLASS: any_class_r <= cfg_wdata;
          evq_pkg::CFG_ANY_TYPE:  any_type_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= evq_pkg::CNT_W'(evq_pkg::DEPTH))
    else $error("occupancy above depth");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != occ_nxt) |-> (state_r == S_IDLE || state_r == S_SCMP || state_r == S_MWR))
    else $error("occupancy changed outside a post or take completion");

  a_drop_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (drop_r != drop_nxt) |-> (in_acc && occ_r == evq_pkg::CNT_W'(evq_pkg::DEPTH)))
    else $error("drop count moved without a post into a full queue");

  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MWR) |-> (j_ext + 1'b1 < occ_r))
    else $error("compaction ran past live entries");

endmodule
